[rtl/core/dfog_pkg.sv]
// Package for the depth fog pixel blender: function codes, controller
// states, command/status structs and channel masks. No dependencies.
package dfog_pkg;

  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_RECIP = 2'd1;
  localparam logic [1:0] FUNC_EXP   = 2'd2;

  localparam logic [2:0] REG_FOG_COLOR    = 3'd0;
  localparam logic [2:0] REG_FOG_DENSITY  = 3'd1;
  localparam logic [2:0] REG_Z_STEP       = 3'd2;
  localparam logic [2:0] REG_PIXEL_FORMAT = 3'd3;
  localparam logic [2:0] REG_FOG_MODE     = 3'd4;

  localparam logic [15:0] MASK_R565 = 16'hf800;
  localparam logic [15:0] MASK_G565 = 16'h07e0;
  localparam logic [15:0] MASK_R555 = 16'h7c00;
  localparam logic [15:0] MASK_G555 = 16'h03e0;
  localparam logic [15:0] MASK_B    = 16'h001f;

  localparam logic [32:0] Z_LIMIT = 33'h1000000;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RECIP = 5'b00010,
    ST_THICK = 5'b00100,
    ST_EXP   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input item, step depth, issue recip reads
    logic thick;     // form thickness from recip data
    logic blend;     // blend with exp data
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pixel;
  } dp_status_t;

endpackage

[rtl/core/depth_fog_pixel_blender_unit.sv]
// Depth fog pixel blender top level: config registers, controller, datapath.
// Depends on dfog_pkg, dfog_ctrl, dfog_datapath.
// A pixel passes through the recip read, thickness multiply, exp read and
// output states; a new item is taken only in idle or as the result is taken.
// Table writes give no item.
// Reset (synchronous) clears config to defaults and running depth to zero;
// tables are undefined until written.
module depth_fog_pixel_blender_unit
  import dfog_pkg::*;
#(
  parameter int RECIP_DEPTH = 4096,
  parameter int EXP_SIZE    = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [11:0] table_index, [35:12] table_value, [51:36] pixel_in,
  // [83:52] depth_in, [115:84] start_depth
  input  logic [119:0] s_tdata,
  // [1:0] func, [2] span_start
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [15:0] pixel_out
  output logic [15:0]  m_tdata,
  // [0] fogged
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [15:0] fog_color, fog_density;
  logic [31:0] z_step;
  logic        pixel_format, fog_mode;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // hold config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fog_color <= '0; fog_density <= '0; z_step <= '0;
      pixel_format <= 1'b1; fog_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOG_COLOR:    fog_color <= cfg_data[15:0];
        REG_FOG_DENSITY:  fog_density <= cfg_data[15:0];
        REG_Z_STEP:       z_step <= cfg_data;
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        REG_FOG_MODE:     fog_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dfog_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready), .status(status), .cmd(cmd));

  dfog_datapath #(.RECIP_DEPTH(RECIP_DEPTH), .EXP_SIZE(EXP_SIZE)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .func(s_tuser[1:0]), .table_index(s_tdata[11:0]),
    .table_value(s_tdata[35:12]), .pixel_in(s_tdata[51:36]),
    .depth_in(s_tdata[83:52]), .span_start(s_tuser[2]),
    .start_depth(s_tdata[115:84]),
    .fog_color(fog_color), .fog_density(fog_density), .z_step(z_step),
    .pixel_format(pixel_format), .fog_mode(fog_mode),
    .pixel_out(m_tdata), .fogged(m_tuser));

  // hold the result item while stalled, and take no input meanwhile
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while result stalled");
endmodule

[rtl/core/dfog_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/dfog_ctrl.sv]
// Controller state machine for the fog blender.
// Depends on dfog_pkg.
module dfog_ctrl
  import dfog_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);
  state_t state, state_next;

  assign in_ready  = (state == ST_IDLE) || (state == ST_OUT && out_ready);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    cmd = '0;
    cmd.capture = in_ready && in_valid;
    cmd.thick = (state == ST_RECIP);
    cmd.blend = (state == ST_EXP);
  end

  // advance through recip read, thickness, exp read, output
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && status.is_pixel) state_next = ST_RECIP;
      end
      ST_RECIP: state_next = ST_THICK;
      ST_THICK: state_next = ST_EXP;
      ST_EXP:   state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          if (in_valid && status.is_pixel) state_next = ST_RECIP;
          else state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

[rtl/core/dfog_datapath.sv]
// Datapath for the fog blender: running depth, tables, thickness and blend.
// Depends on dfog_pkg and dfog_ram.
module dfog_datapath
  import dfog_pkg::*;
#(
  parameter int RECIP_DEPTH = 4096,
  parameter int EXP_SIZE    = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  input  logic [1:0]  func,
  input  logic [11:0] table_index,
  input  logic [23:0] table_value,
  input  logic [15:0] pixel_in,
  input  logic [31:0] depth_in,
  input  logic        span_start,
  input  logic [31:0] start_depth,
  input  logic [15:0] fog_color,
  input  logic [15:0] fog_density,
  input  logic [31:0] z_step,
  input  logic        pixel_format,
  input  logic        fog_mode,
  output logic [15:0] pixel_out,
  output logic        fogged
);
  localparam int RW = $clog2(RECIP_DEPTH);
  localparam int EW = $clog2(EXP_SIZE);

  logic [31:0] running_depth;
  logic [15:0] pix;
  logic        has_fog, coarse, view;

  logic        rwe, ewe;
  logic [RW-1:0] ra_b, ra_z, rwa;
  logic [23:0] rd_b, rd_z;
  logic [8:0]  ed;
  logic [EW-1:0] ea;

  logic signed [41:0] prod;
  logic        sat;

  assign status.is_pixel = (func == FUNC_PIXEL);

  // table writes beyond the depth are dropped
  assign rwe = cmd.capture && func == FUNC_RECIP &&
               ({20'd0, table_index} < 32'(RECIP_DEPTH));
  assign ewe = cmd.capture && func == FUNC_EXP &&
               ({20'd0, table_index} < 32'(EXP_SIZE));
  assign rwa = RW'(table_index);

  function automatic logic [RW-1:0] sat_idx(input logic [19:0] idx);
    if ({12'd0, idx} >= 32'(RECIP_DEPTH)) return RW'(RECIP_DEPTH - 1);
    return idx[RW-1:0];
  endfunction

  logic [31:0] z_cur;
  assign z_cur = span_start ? start_depth : running_depth;
  assign ra_b = sat_idx(depth_in[31:12]);
  assign ra_z = sat_idx({8'd0, z_cur[31:20]}) ^
                ((z_cur >= Z_LIMIT[31:0]) ? RW'(0) :
                 (sat_idx({8'd0, z_cur[31:20]}) ^ sat_idx(z_cur[31:12])));

  // both recip copies take the same table write (shared write port)
  dfog_ram #(.WIDTH(24), .DEPTH(RECIP_DEPTH)) u_recip_b (
    .clk(clk), .we(rwe), .waddr(rwa), .wdata(table_value),
    .raddr(ra_b), .rdata(rd_b));
  dfog_ram #(.WIDTH(24), .DEPTH(RECIP_DEPTH)) u_recip_z (
    .clk(clk), .we(rwe), .waddr(rwa), .wdata(table_value),
    .raddr(ra_z), .rdata(rd_z));

  // capture pixel, decide fog, step running depth
  always_ff @(posedge clk) begin
    if (rst) begin
      running_depth <= '0;
    end else if (cmd.capture && func == FUNC_PIXEL) begin
      running_depth <= z_cur + z_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && func == FUNC_PIXEL) begin
      pix  <= pixel_in;
      view <= fog_mode;
      coarse <= (z_cur >= Z_LIMIT[31:0]);
      if (fog_mode) has_fog <= depth_in < Z_LIMIT[31:0];
      else has_fog <= (z_cur > depth_in) && (depth_in < Z_LIMIT[31:0]);
    end
  end

  // thickness: density times recip difference (recip alone in view mode), floored, clamped
  logic signed [25:0] diff;
  logic signed [42:0] tfull;
  always_comb begin
    if (view) diff = $signed({2'b0, rd_b});
    else if (coarse) diff = $signed({2'b0, rd_b}) - $signed({10'd0, rd_z[23:8]});
    else diff = $signed({2'b0, rd_b}) - $signed({2'b0, rd_z});
    tfull = $signed({1'b0, fog_density}) * diff;
  end

  always_ff @(posedge clk) begin
    if (cmd.thick) begin
      prod <= 42'(tfull >>> 12);
    end
  end

  assign sat = !prod[41] && (prod >= 42'(EXP_SIZE));
  assign ea = prod[41] ? EW'(0) : prod[EW-1:0];

  dfog_ram #(.WIDTH(9), .DEPTH(EXP_SIZE)) u_exp (
    .clk(clk), .we(ewe), .waddr(table_index[EW-1:0]),
    .wdata(table_value[8:0]), .raddr(ea), .rdata(ed));

  logic sat_q;
  always_ff @(posedge clk) begin
    if (cmd.thick) sat_q <= 1'b0;
    else if (cmd.blend == 1'b0 && !cmd.capture) sat_q <= sat;
  end

  // blend each channel toward the fog color
  function automatic logic [15:0] blend_ch(input logic [15:0] p,
                                           input logic [15:0] c,
                                           input logic [15:0] m,
                                           input logic [8:0] f);
    logic signed [17:0] d;
    logic signed [27:0] v;
    d = $signed({2'b0, p & m}) - $signed({2'b0, c & m});
    v = ($signed({1'b0, f}) * d) >>> 8;
    v = v + $signed({12'd0, c & m});
    return v[15:0] & m;
  endfunction

  logic [15:0] mr, mg, res;
  assign mr = pixel_format ? MASK_R565 : MASK_R555;
  assign mg = pixel_format ? MASK_G565 : MASK_G555;
  always_comb begin
    if (sat_q) res = fog_color & (mr | mg | MASK_B);
    else res = blend_ch(pix, fog_color, mr, ed) |
               blend_ch(pix, fog_color, mg, ed) |
               blend_ch(pix, fog_color, MASK_B, ed);
  end

  always_ff @(posedge clk) begin
    if (cmd.blend) begin
      pixel_out <= has_fog ? res : pix;
      fogged    <= has_fog;
    end
  end
endmodule

[tb/depth_fog_pixel_blender_unit_tb.sv]
// Self-checking testbench for depth_fog_pixel_blender_unit: table loads, directed and
// random pixel spans under several register settings, checked against a built-in predictor.
// Depends on dfog_pkg and the depth_fog_pixel_blender_unit RTL.
`timescale 1ns / 100ps

module depth_fog_pixel_blender_unit_tb;
  import dfog_pkg::*;

  localparam int RECIP_DEPTH = 4096;
  localparam int EXP_SIZE    = 1024;
  localparam int SETTLE      = 8;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    logic [1:0]  func;
    logic [11:0] tidx;
    logic [23:0] tval;
    logic [15:0] pix;
    logic [31:0] depth;
    logic        sstart;
    logic [31:0] sdepth;
  } fog_item_t;

  typedef enum {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t    kind;
    fog_item_t   it;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
  } op_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [11:0] table_index, [35:12] table_value, [51:36] pixel_in,
  // [83:52] depth_in, [115:84] start_depth
  logic [119:0] s_tdata = '0;
  // [1:0] func, [2] span_start
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [15:0] pixel_out
  logic [15:0]  m_tdata;
  // [0] fogged
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  depth_fog_pixel_blender_unit i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state and registers
  logic [23:0] recip_mem [RECIP_DEPTH];
  logic [8:0]  exp_mem [EXP_SIZE];
  logic [31:0] run_depth = '0;
  logic [15:0] m_color = '0;
  logic [15:0] m_density = '0;
  logic [31:0] m_zstep = '0;
  logic        m_fmt = 1'b1;
  logic        m_mode = 1'b0;

  op_t          op_q[$];
  logic [16:0]  expected_pixels[$];   // {fogged, pixel_out}
  fog_item_t    cur_item;
  logic         taken = 1'b0;
  int           idle_cycles = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  bit           burst = 1'b0;
  int           errors = 0;
  longint       cycle_cnt = 0;

  function automatic logic [15:0] blend_ch(logic [15:0] pix, logic [15:0] mask, longint f);
    longint p, c, v;
    p = longint'(pix & mask);
    c = longint'(m_color & mask);
    v = ((f * (p - c)) >>> 8) + c;
    return v[15:0] & mask;
  endfunction

  // Update the table/depth state for one item and queue its result, if any.
  task automatic predict_fog(input fog_item_t it);
    logic [31:0] z;
    logic [15:0] mr, mg, res;
    logic        fog;
    longint      diff, t, f;
    fog = 1'b0;
    diff = 0;
    if (it.func == FUNC_RECIP) begin
      recip_mem[it.tidx] = it.tval;
      return;
    end
    if (it.func == FUNC_EXP) begin
      if (it.tidx < EXP_SIZE) exp_mem[it.tidx] = it.tval[8:0];
      return;
    end
    if (it.func != FUNC_PIXEL) return;
    if (it.sstart) run_depth = it.sdepth;
    z = run_depth;
    run_depth = run_depth + m_zstep;
    if (m_mode) begin
      if (it.depth < Z_LIMIT) begin
        fog = 1'b1;
        diff = longint'(recip_mem[it.depth >> 12]);
      end
    end else if (z >= Z_LIMIT) begin
      // coarse path for far running depth
      if (it.depth < Z_LIMIT && z > it.depth) begin
        fog = 1'b1;
        diff = longint'(recip_mem[it.depth >> 12]) - longint'(recip_mem[z >> 20] >> 8);
      end
    end else if (z > it.depth) begin
      fog = 1'b1;
      diff = longint'(recip_mem[it.depth >> 12]) - longint'(recip_mem[z >> 12]);
    end
    t = (longint'(m_density) * diff) >>> 12;
    if (t < 0) t = 0;
    mr = m_fmt ? MASK_R565 : MASK_R555;
    mg = m_fmt ? MASK_G565 : MASK_G555;
    if (!fog) res = it.pix;
    else if (t >= EXP_SIZE) res = m_color & (mr | mg | MASK_B);
    else begin
      f = longint'(exp_mem[t]);
      res = blend_ch(it.pix, mr, f) | blend_ch(it.pix, mg, f) | blend_ch(it.pix, MASK_B, f);
    end
    expected_pixels.push_back({fog, res});
  endtask

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 99) == 0) burst = !burst;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sample handshakes, feed the predictor, check results.
  always @(posedge clk) begin
    logic [16:0] exp_res;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (!rst && cfg_we) begin
        case (cfg_index)
          REG_FOG_COLOR:    m_color = cfg_data[15:0];
          REG_FOG_DENSITY:  m_density = cfg_data[15:0];
          REG_Z_STEP:       m_zstep = cfg_data;
          REG_PIXEL_FORMAT: m_fmt = cfg_data[0];
          REG_FOG_MODE:     m_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (!rst && s_tvalid && s_tready) predict_fog(cur_item);
      taken <= !rst && s_tvalid && s_tready;
      if (!rst && m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected item: pixel_out %h fogged %b", m_tdata, m_tuser);
          errors++;
        end else begin
          exp_res = expected_pixels.pop_front();
          if (m_tdata !== exp_res[15:0]) begin
            $error("pixel_out expected %h actual %h", exp_res[15:0], m_tdata);
            errors++;
          end
          if (m_tuser !== exp_res[16]) begin
            $error("fogged expected %b actual %b", exp_res[16], m_tuser);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || m_tvalid || expected_pixels.size() != 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive items and register writes at the falling edge.
  always @(negedge clk) begin
    logic nvalid, nwe;
    op_t  op;
    nvalid = 1'b0;
    nwe = 1'b0;
    if (!rst) begin
      if (s_tvalid && !taken) begin
        nvalid = 1'b1;  // hold until accepted
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (op_q.size() != 0) begin
        op = op_q[0];
        case (op.kind)
          OP_ITEM: begin
            cur_item = op.it;
            s_tdata <= {4'b0, op.it.sdepth, op.it.depth, op.it.pix, op.it.tval, op.it.tidx};
            s_tuser <= {op.it.sstart, op.it.func};
            nvalid = 1'b1;
            void'(op_q.pop_front());
            gap_left = pick_gap();
          end
          OP_CFG: begin
            if (!cfg_we && expected_pixels.size() == 0 && idle_cycles >= SETTLE) begin
              cfg_index <= op.reg_idx;
              cfg_data <= op.reg_val;
              nwe = 1'b1;
              void'(op_q.pop_front());
            end
          end
          default: begin
            if (expected_pixels.size() == 0) void'(op_q.pop_front());
          end
        endcase
      end
      // receiver stalls
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!burst) stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                               : $urandom_range(0, 2);
      end
    end
    s_tvalid <= nvalid;
    cfg_we <= nwe;
  end

  task automatic push_item(input logic [1:0] func, input logic [11:0] tidx,
                           input logic [23:0] tval, input logic [15:0] pix,
                           input logic [31:0] depth, input logic sstart,
                           input logic [31:0] sdepth);
    op_t op;
    op.kind = OP_ITEM;
    op.it = '{func, tidx, tval, pix, depth, sstart, sdepth};
    op.reg_idx = '0;
    op.reg_val = '0;
    op_q.push_back(op);
  endtask

  task automatic push_cfg(input logic [2:0] idx, input logic [31:0] val);
    op_t op;
    op.kind = OP_CFG;
    op.it = '{FUNC_PIXEL, 12'd0, 24'd0, 16'd0, 32'd0, 1'b0, 32'd0};
    op.reg_idx = idx;
    op.reg_val = val;
    op_q.push_back(op);
  endtask

  // Random mix: mostly spans of pixels, some table rewrites and junk codes.
  task automatic push_random(input int count);
    int span_left, r;
    logic [31:0] sd, d;
    span_left = 0;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4) push_item(FUNC_RECIP, 12'($urandom), 24'($urandom), 16'($urandom),
                           $urandom, 1'($urandom), $urandom);
      else if (r < 7) push_item(FUNC_EXP, 12'($urandom), 24'($urandom), 16'($urandom),
                                $urandom, 1'($urandom), $urandom);
      else if (r < 9) push_item(2'd3, 12'($urandom), 24'($urandom), 16'($urandom),
                                $urandom, 1'($urandom), $urandom);
      else begin
        r = $urandom_range(0, 9);
        sd = (r < 8) ? $urandom_range(0, 32'h00ffffff) :
             (r < 9) ? $urandom_range(32'h01000000, 32'h0fffffff) : $urandom;
        r = $urandom_range(0, 9);
        d = (r < 6) ? $urandom_range(0, 32'h00ffffff) :
            (r < 8) ? $urandom_range(0, 32'h000fffff) : $urandom;
        push_item(FUNC_PIXEL, 12'($urandom), 24'($urandom), 16'($urandom), d,
                  span_left == 0, sd);
        if (span_left == 0) span_left = $urandom_range(1, 16);
        span_left--;
      end
    end
  endtask

  initial begin
    logic [15:0] colors [6];
    logic [15:0] dens [6];
    logic [31:0] steps [6];
    logic        fmts [6];
    logic        modes [6];
    op_t         drain;
    colors = '{16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'h8421, 16'h0000};
    dens   = '{16'd1, 16'd16, 16'hffff, 16'd0, 16'd4, 16'd0};
    steps  = '{32'h0, 32'h1000, 32'h7fffffff, 32'hfffff800, 32'h80000000, 32'h0};
    fmts   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    modes  = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    colors[1] = 16'($urandom);
    colors[3] = 16'($urandom);
    colors[5] = 16'($urandom);
    dens[5] = 16'($urandom_range(1, 300));
    steps[5] = $urandom;
    drain.kind = OP_DRAIN;
    drain.it = '{FUNC_PIXEL, 12'd0, 24'd0, 16'd0, 32'd0, 1'b0, 32'd0};
    drain.reg_idx = '0;
    drain.reg_val = '0;

    // load both tables: reciprocal falls with depth index, exp random
    for (int i = 0; i < RECIP_DEPTH; i++)
      push_item(FUNC_RECIP, 12'(i), 24'(24'hffffff / (i + 1)), 16'($urandom), $urandom,
                1'b0, $urandom);
    for (int i = 0; i < EXP_SIZE; i++)
      push_item(FUNC_EXP, 12'(i), 24'($urandom), 16'($urandom), $urandom, 1'b0, $urandom);

    for (int p = 0; p < 6; p++) begin
      push_cfg(REG_FOG_COLOR, {16'h0, colors[p]});
      push_cfg(REG_FOG_DENSITY, {16'h0, dens[p]});
      push_cfg(REG_Z_STEP, steps[p]);
      push_cfg(REG_PIXEL_FORMAT, {31'h0, fmts[p]});
      push_cfg(REG_FOG_MODE, {31'h0, modes[p]});
      if (p == 0) begin
        // field extremes, pass-through, coarse path, ignored writes and junk code
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'h0000, 32'h0, 1'b1, 32'h00ffffff);
        push_item(FUNC_PIXEL, 12'hfff, 24'hffffff, 16'hffff, 32'h00000000, 1'b0, 32'h0);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'hffff, 32'hffffffff, 1'b1, 32'hffffffff);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'h1234, 32'h00100000, 1'b1, 32'h05000000);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'h8001, 32'h00fff000, 1'b1, 32'h00fff000);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'h7bef, 32'h00800000, 1'b1, 32'h00800001);
        push_item(FUNC_EXP, 12'hfff, 24'hffffff, 16'h0, 32'h0, 1'b0, 32'h0);
        push_item(FUNC_EXP, 12'd1023, 24'h000100, 16'h0, 32'h0, 1'b0, 32'h0);
        push_item(2'd3, 12'hfff, 24'hffffff, 16'hffff, 32'hffffffff, 1'b1, 32'hffffffff);
        // non-monotone entry makes a negative thickness
        push_item(FUNC_RECIP, 12'd2, 24'h000000, 16'h0, 32'h0, 1'b0, 32'h0);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'hf00f, 32'h00002000, 1'b1, 32'h00003000);
        push_item(FUNC_RECIP, 12'hfff, 24'hffffff, 16'h0, 32'h0, 1'b0, 32'h0);
        push_item(FUNC_PIXEL, 12'h0, 24'h0, 16'h0f0f, 32'h00000000, 1'b1, 32'h00fff800);
      end
      push_random(170);
      if (p == 2) op_q.push_back(drain);
      push_random(170);
    end

    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    while (op_q.size() != 0 || s_tvalid || expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
